/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the key frequency tracker RTL.
// Needs a clk and an rst signal in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge out of reset
`define KFMT_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("kfmt assertion failed");

// cons must hold at the edge where ante holds
`define KFMT_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kfmt assertion failed");

// cons must hold at the edge after the one where ante holds
`define KFMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kfmt assertion failed");

`endif

/* hw/rtl/kfmt_pkg.sv */
// Package for the key frequency tracker: sizes, key and request types, states.
// No dependencies.
`default_nettype none

package kfmt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int KEY_WORDS     = 5;
  localparam int WORD_W        = 64;
  localparam int COUNT_W       = 16;
  localparam int DISTINCT_W    = 7;
  localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  rd_addr;
    logic [SLOT_W-1:0]  wr_addr;
    logic               key_we;
    logic               cnt_we;
    logic [COUNT_W-1:0] wr_count;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_FIN,
    ST_REPORT
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/kfmt_slot_mem.sv */
// Slot storage: one key row and one count per table slot, registered read.
// Depends on kfmt_pkg.
`default_nettype none

module kfmt_slot_mem (
  input  wire                           clk,
  input  wire kfmt_pkg::mem_req_t       req,
  input  wire kfmt_pkg::key_t           wr_key,
  output kfmt_pkg::key_t                rd_key,
  output logic [kfmt_pkg::COUNT_W-1:0]  rd_count
);

  kfmt_pkg::key_t               key_mem [kfmt_pkg::TABLE_ENTRIES];
  logic [kfmt_pkg::COUNT_W-1:0] cnt_mem [kfmt_pkg::TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.key_we) begin
      key_mem[req.wr_addr] <= wr_key;
    end
    rd_key <= key_mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (req.cnt_we) begin
      cnt_mem[req.wr_addr] <= req.wr_count;
    end
    rd_count <= cnt_mem[req.rd_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/kfmt_match.sv */
// Shared key comparator and saturating count increment for one stored slot.
// Depends on kfmt_pkg.
`default_nettype none

module kfmt_match (
  input  wire kfmt_pkg::key_t           probe,
  input  wire kfmt_pkg::key_t           stored,
  input  wire [kfmt_pkg::COUNT_W-1:0]   stored_count,
  output logic                          hit,
  output logic [kfmt_pkg::COUNT_W-1:0]  count_inc
);

  assign hit = (probe == stored);
  assign count_inc = (stored_count == kfmt_pkg::COUNT_MAX) ?
                     stored_count : stored_count + kfmt_pkg::COUNT_W'(1);

endmodule

`default_nettype wire

/* hw/rtl/key_frequency_mode_tracker.sv */
// Top level of the key frequency tracker: sequencer, set state, result register.
// Depends on kfmt_pkg, kfmt_slot_mem, kfmt_match and assert_macros.svh.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  key_word0..key_word4, last_item
//   out      out_valid / out_stall best_word0..best_word4, best_count,
//                                  distinct_count, table_overflow
//
// An item runs through SCAN (up to TABLE_ENTRIES slots, none in an empty set), then
// INSERT on a new key, then FIN, and on a last item REPORT, which waits for a
// free result register. The single key comparator visits one slot a cycle.
// The input is stalled while an item is in work; the result register lets the
// next item in while a report waits. Reset clears the set; the slot memory is
// not cleared, the fill count marks the live slots.
`default_nettype none

module key_frequency_mode_tracker (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [63:0] key_word0,
  input  wire  [63:0] key_word1,
  input  wire  [63:0] key_word2,
  input  wire  [63:0] key_word3,
  input  wire  [63:0] key_word4,
  input  wire         last_item,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [63:0] best_word0,
  output logic [63:0] best_word1,
  output logic [63:0] best_word2,
  output logic [63:0] best_word3,
  output logic [63:0] best_word4,
  output logic [15:0] best_count,
  output logic [6:0]  distinct_count,
  output logic        table_overflow
);

  localparam int SLOT_W  = kfmt_pkg::SLOT_W;
  localparam int USED_W  = kfmt_pkg::USED_W;
  localparam int COUNT_W = kfmt_pkg::COUNT_W;

  kfmt_pkg::state_t   state, state_next;
  kfmt_pkg::key_t     key;
  logic               last_flag;
  logic [SLOT_W-1:0]  slot;
  logic [USED_W-1:0]  used_slots;
  logic [SLOT_W-1:0]  best_slot;
  logic [COUNT_W-1:0] best_so_far;
  logic               overflow_seen;

  kfmt_pkg::mem_req_t req;
  kfmt_pkg::key_t     rd_key;
  logic [COUNT_W-1:0] rd_count;
  logic               hit;
  logic [COUNT_W-1:0] count_inc;

  logic               accept;
  logic               load;
  logic               more;
  logic               table_full;
  logic               slot_step;
  logic               slot_clear;
  logic               insert;
  logic               set_overflow;
  logic               cand_valid;
  logic [SLOT_W-1:0]  cand_slot;
  logic [COUNT_W-1:0] cand_count;

  kfmt_slot_mem u_mem (
    .clk      (clk),
    .req      (req),
    .wr_key   (key),
    .rd_key   (rd_key),
    .rd_count (rd_count)
  );

  kfmt_match u_match (
    .probe        (key),
    .stored       (rd_key),
    .stored_count (rd_count),
    .hit          (hit),
    .count_inc    (count_inc)
  );

  assign in_stall   = (state != kfmt_pkg::ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign more       = ((USED_W'(slot) + USED_W'(1)) < used_slots);
  assign table_full = (used_slots >= USED_W'(kfmt_pkg::TABLE_ENTRIES));

  always_comb begin
    state_next    = state;
    req.rd_addr   = '0;
    req.wr_addr   = slot;
    req.key_we    = 1'b0;
    req.cnt_we    = 1'b0;
    req.wr_count  = count_inc;
    slot_step     = 1'b0;
    slot_clear    = 1'b0;
    insert        = 1'b0;
    set_overflow  = 1'b0;
    cand_valid    = 1'b0;
    cand_slot     = slot;
    cand_count    = count_inc;
    load          = 1'b0;
    unique case (state)
      kfmt_pkg::ST_IDLE: begin
        slot_clear = 1'b1;
        if (accept) begin
          state_next = (used_slots == '0) ? kfmt_pkg::ST_INSERT : kfmt_pkg::ST_SCAN;
        end
      end
      kfmt_pkg::ST_SCAN: begin
        req.rd_addr = slot + SLOT_W'(1);
        if (hit) begin
          req.cnt_we = 1'b1;
          cand_valid = 1'b1;
          state_next = kfmt_pkg::ST_FIN;
        end else if (more) begin
          slot_step = 1'b1;
        end else begin
          state_next = kfmt_pkg::ST_INSERT;
        end
      end
      kfmt_pkg::ST_INSERT: begin
        req.wr_addr  = used_slots[SLOT_W-1:0];
        req.wr_count = COUNT_W'(1);
        cand_slot    = used_slots[SLOT_W-1:0];
        cand_count   = COUNT_W'(1);
        if (table_full) begin
          set_overflow = 1'b1;
        end else begin
          req.key_we = 1'b1;
          req.cnt_we = 1'b1;
          insert     = 1'b1;
          cand_valid = 1'b1;
        end
        state_next = kfmt_pkg::ST_FIN;
      end
      kfmt_pkg::ST_FIN: begin
        req.rd_addr = best_slot;
        state_next  = last_flag ? kfmt_pkg::ST_REPORT : kfmt_pkg::ST_IDLE;
      end
      kfmt_pkg::ST_REPORT: begin
        req.rd_addr = best_slot;
        if (!out_valid || !out_stall) begin
          load       = 1'b1;
          state_next = kfmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kfmt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kfmt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot          <= '0;
      used_slots    <= '0;
      best_slot     <= '0;
      best_so_far   <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (slot_clear) begin
        slot <= '0;
      end else if (slot_step) begin
        slot <= slot + SLOT_W'(1);
      end
      if (insert) begin
        used_slots <= used_slots + USED_W'(1);
      end
      if (set_overflow) begin
        overflow_seen <= 1'b1;
      end
      if (cand_valid) begin
        if (cand_count > best_so_far) begin
          best_so_far <= cand_count;
          best_slot   <= cand_slot;
        end else if (cand_count == best_so_far && cand_slot < best_slot) begin
          best_slot <= cand_slot;
        end
      end
      if (load) begin
        used_slots    <= '0;
        best_slot     <= '0;
        best_so_far   <= '0;
        overflow_seen <= 1'b0;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key       <= {key_word4, key_word3, key_word2, key_word1, key_word0};
      last_flag <= last_item;
    end
    if (load) begin
      best_word0     <= rd_key[0];
      best_word1     <= rd_key[1];
      best_word2     <= rd_key[2];
      best_word3     <= rd_key[3];
      best_word4     <= rd_key[4];
      best_count     <= best_so_far;
      distinct_count <= 7'(used_slots);
      table_overflow <= overflow_seen;
    end
  end

`include "assert_macros.svh"

  `KFMT_ASSERT_ALWAYS(a_used_bound, used_slots <= USED_W'(kfmt_pkg::TABLE_ENTRIES))
  `KFMT_ASSERT_IMPLY(a_best_live, best_so_far != '0, USED_W'(best_slot) < used_slots)
  `KFMT_ASSERT_IMPLY(a_scan_live, state == kfmt_pkg::ST_SCAN, USED_W'(slot) < used_slots)
  `KFMT_ASSERT_NEXT(a_report_clears, load, used_slots == '0 && best_so_far == '0 && out_valid)

endmodule

`default_nettype wire
